@@ hdl/jhe_pkg.sv @@
package jhe_pkg;

  localparam int BlockCoeffs = 64;
  localparam int Components  = 3;
  localparam int CodeLenW    = 5;
  localparam int CodeW       = 16;

  typedef enum logic [1:0] {
    OP_COEF   = 2'd0,
    OP_START  = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  // One Huffman code plus one run of raw bits, as handed from front to back.
  typedef struct packed {
    logic                is_finish;
    logic                is_start;
    logic [CodeLenW-1:0] sym_len;
    logic [CodeW-1:0]    sym_code;
    logic [CodeLenW-1:0] amp_len;
    logic [CodeW-1:0]    amp_bits;
  } work_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       image_end;
  } result_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  component;
    logic [10:0] coefficient;
  } item_t;

  // Canonical code of a symbol: returns {len, code}; len 0 when absent.
  function automatic logic [20:0] huff_lookup(input logic chroma, input logic dc,
                                              input logic [7:0] sym);
    logic [7:0] cnt [16];
    logic [7:0] syms [162];
    logic [20:0] res;
    int unsigned code;
    int unsigned k;
    res  = '0;
    code = 0;
    k    = 0;
    if (dc) begin
      if (!chroma) cnt = '{0,1,5,1,1,1,1,1,1,0,0,0,0,0,0,0};
      else         cnt = '{0,3,1,1,1,1,1,1,1,1,1,0,0,0,0,0};
      for (int i = 0; i < 162; i++) syms[i] = (i < 12) ? 8'(i) : 8'hFF;
    end else if (!chroma) begin
      cnt = '{0,2,1,3,3,2,4,3,5,5,4,4,0,0,1,8'h7d};
      syms = '{
8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,8'h61,8'h07,
8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,8'h15,8'h52,8'hd1,8'hf0,
8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,
8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,
8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,
8'h6a,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,
8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,8'he1,8'he2,
8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,
8'hf9,8'hfa};
    end else begin
      cnt = '{0,2,1,2,4,4,3,4,7,5,4,4,0,1,2,8'h77};
      syms = '{
8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,8'h61,8'h71,
8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,8'hc1,8'h09,8'h23,8'h33,8'h52,8'hf0,
8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,
8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,
8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,
8'h69,8'h6a,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,
8'h88,8'h89,8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,
8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,
8'hf9,8'hfa};
    end
    for (int len = 1; len <= 16; len++) begin
      for (int i = 0; i < 256; i++) begin
        if (i < int'(cnt[len-1])) begin
          if (k < 162 && syms[k] == sym && !(dc && k >= 12)) begin
            res = {5'(len), 16'(code)};
          end
          k++;
          code++;
        end
      end
      code = code << 1;
    end
    return res;
  endfunction

  // Category of a magnitude up to 2047.
  function automatic logic [3:0] category(input logic [10:0] mag);
    logic [3:0] m;
    m = '0;
    for (int b = 0; b < 11; b++) begin
      if (mag[b]) m = 4'(b + 1);
    end
    return m;
  endfunction

endpackage

@@ hdl/jhe_stream_if.sv @@
interface jhe_stream_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/jhe_front.sv @@
// Classify a transaction: DC/AC coding, zero runs and ZRL expansion.
module jhe_front #(
  parameter int unsigned NumComp = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  jhe_pkg::item_t    in_item_i,
  output logic              in_ready_o,
  output logic              wk_valid_o,
  output jhe_pkg::work_t    wk_o,
  input  logic              wk_ready_i
);
  import jhe_pkg::*;

  localparam int unsigned CompW = (NumComp > 1) ? $clog2(NumComp) : 1;

  logic signed [10:0] pred_q [NumComp];
  logic [5:0]  pos_q, pos_d;
  logic [5:0]  run_q, run_d;
  item_t       held_q;
  logic        busy_q;

  logic [1:0]  op;
  logic [CompW-1:0] comp;
  logic        chroma;
  logic signed [11:0] diff;
  logic signed [10:0] ac;
  logic [10:0] mag;
  logic [3:0]  cat;
  logic [20:0] sym_ent;
  logic [15:0] amp;
  logic        go, last;

  item_t cur;
  assign cur = busy_q ? held_q : in_item_i;
  assign op  = cur.opcode;
  always_comb begin
    if (32'(cur.component) >= NumComp) comp = CompW'(NumComp - 1);
    else comp = CompW'(cur.component);
  end
  assign chroma = (comp != '0);
  assign last   = (32'(pos_q) >= BlockCoeffs - 1);

  always_comb begin
    diff = 12'(signed'(cur.coefficient)) - 12'(pred_q[comp]);
    ac   = signed'(cur.coefficient);
    if (ac == -11'sd1024) ac = -11'sd1023;
    if (pos_q == '0) mag = diff[11] ? 11'(-diff) : diff[10:0];
    else mag = ac[10] ? 11'(-ac) : ac;
    cat = category(mag);
    if (pos_q == '0) amp = diff[11] ? 16'(diff - 12'sd1) : 16'(diff);
    else amp = ac[10] ? 16'(12'(ac) - 12'sd1) : 16'(ac);
  end

  // one ROM lookup: DC category, ZRL, EOB, or run/size
  logic [7:0] sym;
  logic       is_dc;
  assign is_dc = (op == OP_COEF) && (pos_q == '0);
  always_comb begin
    if (is_dc) sym = {4'd0, cat};
    else if (ac == '0) sym = 8'h00;
    else if (run_q >= 6'd16) sym = 8'hF0;
    else sym = {run_q[3:0], cat};
  end
  // each table class is its own constant table; pick among them
  assign sym_ent = is_dc ?
                   (chroma ? huff_lookup(1'b1, 1'b1, sym) : huff_lookup(1'b0, 1'b1, sym)) :
                   (chroma ? huff_lookup(1'b1, 1'b0, sym) : huff_lookup(1'b0, 1'b0, sym));

  logic emit_now, zrl_step, done;
  always_comb begin
    wk_o       = '0;
    emit_now   = 1'b0;
    zrl_step   = 1'b0;
    done       = 1'b1;
    pos_d      = pos_q;
    run_d      = run_q;
    wk_o.sym_len  = sym_ent[20:16];
    wk_o.sym_code = sym_ent[15:0];
    case (op)
      OP_START: begin
        wk_o.is_start = 1'b1; wk_o.sym_len = '0; emit_now = 1'b1;
        pos_d = '0; run_d = '0;
      end
      OP_FINISH: begin
        wk_o.is_finish = 1'b1; wk_o.sym_len = '0; emit_now = 1'b1;
        pos_d = '0; run_d = '0;
      end
      OP_COEF: begin
        if (pos_q == '0) begin
          emit_now = 1'b1;
          wk_o.amp_len  = {1'b0, cat};
          wk_o.amp_bits = amp;
          run_d = '0;
        end else if (ac == '0) begin
          run_d = run_q + 6'd1;
          if (last) begin
            emit_now = 1'b1; run_d = '0;
          end
        end else if (run_q >= 6'd16) begin
          emit_now = 1'b1; zrl_step = 1'b1; done = 1'b0;
          run_d = run_q - 6'd16;
        end else begin
          emit_now = 1'b1;
          wk_o.amp_len  = {1'b0, cat};
          wk_o.amp_bits = amp;
          run_d = '0;
        end
        if (done) pos_d = last ? '0 : pos_q + 6'd1;
        if (done && last) run_d = '0;
      end
      default: ;
    endcase
  end

  assign go         = busy_q || in_valid_i;
  assign wk_valid_o = go && emit_now;
  logic step;
  assign step       = go && (!emit_now || wk_ready_i);
  // Accept on the first step; a ZRL expansion then runs on from the held copy.
  assign in_ready_o = !busy_q && (!emit_now || wk_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      run_q  <= '0;
      busy_q <= 1'b0;
      for (int i = 0; i < NumComp; i++) pred_q[i] <= '0;
    end else begin
      if (!busy_q && step && zrl_step) begin
        busy_q <= 1'b1;
        held_q <= in_item_i;
      end
      if (step) begin
        pos_q <= pos_d;
        run_q <= run_d;
        if (done) busy_q <= 1'b0;
        if (op == OP_START) begin
          for (int i = 0; i < NumComp; i++) pred_q[i] <= '0;
        end
        if (is_dc) pred_q[comp] <= signed'(cur.coefficient);
      end
    end
  end
endmodule

@@ hdl/jhe_fifo.sv @@
// Short queue between front and back.
module jhe_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  input  jhe_pkg::work_t wr_data_i,
  output logic           wr_ready_o,
  output logic           rd_valid_o,
  output jhe_pkg::work_t rd_data_o,
  input  logic           rd_ready_i
);
  import jhe_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  work_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic wr, rd;
  assign wr_ready_o = (32'(cnt_q) < Depth);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (32'(wp_q) == Depth - 1) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (32'(rp_q) == Depth - 1) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

@@ hdl/jhe_back.sv @@
// Bit packer: append code and amplitude, drain bytes, stuff, write EOI.
module jhe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wk_valid_i,
  input  jhe_pkg::work_t  wk_i,
  output logic            wk_ready_o,
  output logic            out_valid_o,
  output jhe_pkg::result_t out_o,
  input  logic            out_ready_i
);
  import jhe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_AMP  = 5'b00010,
    S_DRN  = 5'b00100,
    S_FF   = 5'b01000,
    S_D9   = 5'b10000
  } state_e;

  state_e st_q, st_d;
  logic [22:0] acc_q, acc_d;   // up to 7 held + 16 new bits
  logic [4:0]  cnt_q, cnt_d;
  work_t       wk_q;
  logic        fin_q, fin_d;
  logic        stuff_q, stuff_d;
  logic        ov_q, ov_d;
  result_t     ob_q, ob_d;
  logic        take;
  logic        oslot;

  assign oslot = !ov_q || out_ready_i;

  always_comb begin
    st_d = st_q; acc_d = acc_q; cnt_d = cnt_q; fin_d = fin_q; stuff_d = stuff_q;
    ov_d = ov_q && !out_ready_i; ob_d = ob_q; take = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (wk_valid_i) begin
          take = 1'b1;
          if (wk_i.is_start) begin
            acc_d = '0; cnt_d = '0;
          end else if (wk_i.is_finish) begin
            fin_d = 1'b1;
            if (cnt_q != '0) begin
              acc_d = (acc_q << (5'd8 - cnt_q)) | 23'((8'd1 << (5'd8 - cnt_q)) - 8'd1);
              cnt_d = 5'd8;
              st_d  = S_DRN;
            end else st_d = S_FF;
          end else begin
            acc_d = (wk_i.sym_len == '0) ? acc_q :
                    ((acc_q << wk_i.sym_len) |
                     23'(wk_i.sym_code & 16'((17'd1 << wk_i.sym_len) - 17'd1)));
            cnt_d = cnt_q + wk_i.sym_len;
            st_d  = S_DRN;
            fin_d = 1'b0;
          end
        end
      end
      S_AMP: begin
        acc_d = (acc_q << wk_q.amp_len) |
                23'(wk_q.amp_bits & 16'((17'd1 << wk_q.amp_len) - 17'd1));
        cnt_d = cnt_q + wk_q.amp_len;
        st_d = S_DRN;
      end
      S_DRN: begin
        if (oslot) begin
          if (stuff_q) begin
            ov_d = 1'b1; ob_d = '{8'h00, 1'b0}; stuff_d = 1'b0;
          end else if (cnt_q >= 5'd8) begin
            ov_d = 1'b1;
            ob_d = '{8'(acc_q >> (cnt_q - 5'd8)), 1'b0};
            stuff_d = (8'(acc_q >> (cnt_q - 5'd8)) == 8'hFF);
            cnt_d = cnt_q - 5'd8;
            acc_d = acc_q & ((23'd1 << (cnt_q - 5'd8)) - 23'd1);
          end else if (fin_q) begin
            st_d = S_FF;
          end else if (wk_q.amp_len != '0) begin
            st_d = S_AMP;
          end else st_d = S_IDLE;
        end
      end
      S_FF: begin
        if (oslot) begin
          ov_d = 1'b1; ob_d = '{8'hFF, 1'b0}; st_d = S_D9;
        end
      end
      S_D9: begin
        if (oslot) begin
          ov_d = 1'b1; ob_d = '{8'hD9, 1'b1}; st_d = S_IDLE;
          acc_d = '0; cnt_d = '0; fin_d = 1'b0;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign wk_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_o       = ob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; acc_q <= '0; cnt_q <= '0; fin_q <= 1'b0;
      stuff_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; acc_q <= acc_d; cnt_q <= cnt_d; fin_q <= fin_d;
      stuff_q <= stuff_d; ov_q <= ov_d;
      if (st_q == S_AMP) wk_q.amp_len <= '0;
      else if (take) wk_q <= wk_i;
    end
  end
  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
  end
endmodule

@@ hdl/jpeg_huffman_block_encoder.sv @@
// A coefficient with no output passes through the front only; one with a code
// takes an append step and a drain check in the bit packer, a second append
// and check when amplitude bits follow, plus a drain step per output byte;
// each ZRL is one more front step and one more code. The bit packer, one
// append and one byte per cycle while its output is not stalled, sets the pace.
// Reset: asynchronous, active low; clears predictors, position, run and bits.
module jpeg_huffman_block_encoder #(
  parameter int unsigned COMPONENTS = jhe_pkg::Components
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  jhe_stream_if.sink    in_i,
  jhe_stream_if.source  out_o
);
  import jhe_pkg::*;

  item_t   item;
  result_t res;
  work_t   fw, bw;
  logic    fw_valid, fw_ready, bw_valid, bw_ready;

  // Unpack the input transaction.
  assign item = item_t'(in_i.payload);

  jhe_front #(.NumComp(COMPONENTS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_item_i  (item),
    .in_ready_o (in_i.ready),
    .wk_valid_o (fw_valid),
    .wk_o       (fw),
    .wk_ready_i (fw_ready)
  );

  // Decouple classification from bit packing.
  jhe_fifo #(.Depth(2)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i (fw_valid), .wr_data_i (fw), .wr_ready_o (fw_ready),
    .rd_valid_o (bw_valid), .rd_data_o (bw), .rd_ready_i (bw_ready)
  );

  jhe_back u_back (
    .clk_i, .rst_ni,
    .wk_valid_i  (bw_valid),
    .wk_i        (bw),
    .wk_ready_o  (bw_ready),
    .out_valid_o (out_o.valid),
    .out_o       (res),
    .out_ready_i (out_o.ready)
  );

  assign out_o.payload = res;
endmodule

@@ hdl/jhe_checker.sv @@
module jhe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [8:0] out_payload_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("output changed under stall");
  a_end_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i[0] |-> out_payload_i[8:1] == 8'hD9)
    else $error("end flag off EOI byte");
  a_no_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown(out_payload_i))
    else $error("unknown output byte");
endmodule

bind jpeg_huffman_block_encoder jhe_checker u_chk (
  .clk_i, .rst_ni,
  .out_valid_i (out_o.valid), .out_ready_i (out_o.ready),
  .out_payload_i (out_o.payload)
);

@@ verif/tb_jpeg_huffman_block_encoder.sv @@
module tb_jpeg_huffman_block_encoder;
  import jhe_pkg::*;

  // Stream and result widths follow the packed structs in the package.
  localparam int ItemW   = $bits(item_t);
  localparam int ResultW = $bits(result_t);

  logic clk_i;
  logic rst_ni;

  jhe_stream_if #(.W(ItemW))   coef_if ();
  jhe_stream_if #(.W(ResultW)) byte_if ();

  jpeg_huffman_block_encoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (coef_if.sink),
    .out_o  (byte_if.source)
  );

  // Clock: 10 time units per period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Encoder model: Annex K tables, DC predictors, run counter and bit packer.
  // ---------------------------------------------------------------------------
  logic [20:0] dc_code [2][16];
  logic [20:0] ac_code [2][256];

  logic signed [10:0] pred_dc [3];
  logic [6:0]         acc_bits;
  logic [2:0]         acc_count;
  logic [5:0]         run_len;
  logic [5:0]         position;

  result_t expected_bytes [$];
  item_t   pending_items [$];

  int n_errors;
  int n_bytes_seen;
  int n_items_sent;
  bit quiet_tail;     // last part of the run: no idling on either side
  bit hold_long;      // request for one long receiver hold-off

  // Build the canonical code tables once, from count/symbol lists.
  task automatic build_tables();
    byte unsigned lum_dc_cnt [16] = '{0,1,5,1,1,1,1,1,1,0,0,0,0,0,0,0};
    byte unsigned chr_dc_cnt [16] = '{0,3,1,1,1,1,1,1,1,1,1,0,0,0,0,0};
    byte unsigned lum_ac_cnt [16] = '{0,2,1,3,3,2,4,3,5,5,4,4,0,0,1,8'h7d};
    byte unsigned chr_ac_cnt [16] = '{0,2,1,2,4,4,3,4,7,5,4,4,0,1,2,8'h77};
    byte unsigned lum_ac_sym [162] = '{
      8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
      8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
      8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
      8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
      8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
      8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
      8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
      8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
      8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
      8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
      8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
      8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};
    byte unsigned chr_ac_sym [162] = '{
      8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
      8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,8'hc1,8'h09,
      8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,
      8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,
      8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,
      8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
      8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
      8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
      8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,
      8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,
      8'hd7,8'hd8,8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,
      8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};
    int code;
    int k;
    for (int t = 0; t < 4; t++) begin
      code = 0;
      k = 0;
      for (int s = 0; s < 256; s++) begin
        if (t < 2) ac_code[t][s] = '0;
        else if (s < 16) dc_code[t-2][s] = '0;
      end
      for (int len = 1; len <= 16; len++) begin
        int cnt;
        case (t)
          0: cnt = lum_ac_cnt[len-1];
          1: cnt = chr_ac_cnt[len-1];
          2: cnt = lum_dc_cnt[len-1];
          default: cnt = chr_dc_cnt[len-1];
        endcase
        for (int i = 0; i < cnt; i++) begin
          case (t)
            0: ac_code[0][lum_ac_sym[k]] = {5'(len), 16'(code)};
            1: ac_code[1][chr_ac_sym[k]] = {5'(len), 16'(code)};
            2: dc_code[0][k] = {5'(len), 16'(code)};
            default: dc_code[1][k] = {5'(len), 16'(code)};
          endcase
          k++;
          code++;
        end
        code = code << 1;
      end
    end
  endtask

  function automatic void push_byte(logic [7:0] b, logic last);
    result_t r;
    r.out_byte  = b;
    r.image_end = last;
    expected_bytes.push_back(r);
  endfunction

  // Append code bits MSB first; stuff a zero byte after every 0xFF.
  function automatic void pack_bits(int unsigned code, int unsigned len);
    longint unsigned acc;
    int unsigned cnt;
    if (len == 0 || len > 16) return;
    acc = (longint'(acc_bits) << len) | (code & ((1 << len) - 1));
    cnt = acc_count + len;
    while (cnt >= 8) begin
      logic [7:0] b;
      cnt -= 8;
      b = 8'(acc >> cnt);
      push_byte(b, 1'b0);
      if (b == 8'hFF) push_byte(8'h00, 1'b0);
    end
    acc_count = 3'(cnt);
    acc_bits  = 7'(acc & ((1 << cnt) - 1));
  endfunction

  function automatic int unsigned size_class(int v);
    int unsigned mag;
    int unsigned m;
    mag = (v < 0) ? -v : v;
    m = 0;
    while (m < 16 && (mag >> m) != 0) m++;
    return m;
  endfunction

  function automatic void pack_amplitude(int v, int unsigned cat);
    pack_bits((v < 0) ? (v - 1) : v, cat);
  endfunction

  function automatic void pack_symbol(logic [20:0] e);
    pack_bits(e[15:0], e[20:16]);
  endfunction

  // Expected bytes for one accepted transaction.
  function automatic void encode_item(item_t it);
    int comp;
    int cls;
    int coef;
    int diff;
    int ac;
    int unsigned cat;
    comp = (it.component >= 3) ? 2 : it.component;
    cls  = (comp == 0) ? 0 : 1;
    coef = int'($signed(it.coefficient));
    case (opcode_e'(it.opcode))
      OP_START: begin
        for (int c = 0; c < 3; c++) pred_dc[c] = '0;
        acc_bits = '0; acc_count = '0; run_len = '0; position = '0;
      end
      OP_FINISH: begin
        if (acc_count != 0) pack_bits((1 << (8 - acc_count)) - 1, 8 - acc_count);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hD9, 1'b1);
        acc_bits = '0; acc_count = '0; run_len = '0; position = '0;
      end
      OP_COEF: begin
        if (position == 0) begin
          diff = coef - int'(pred_dc[comp]);
          cat  = size_class(diff);
          pred_dc[comp] = 11'(coef);
          pack_symbol(dc_code[cls][cat & 15]);
          pack_amplitude(diff, cat);
          run_len = '0;
        end else begin
          ac = coef;
          if (ac > 1023) ac = 1023;
          if (ac < -1023) ac = -1023;
          if (ac == 0) begin
            run_len = run_len + 1;
            if (position == 63) begin
              pack_symbol(ac_code[cls][8'h00]);
              run_len = '0;
            end
          end else begin
            cat = size_class(ac);
            while (run_len >= 16) begin
              run_len = run_len - 16;
              pack_symbol(ac_code[cls][8'hF0]);
            end
            pack_symbol(ac_code[cls][8'((run_len << 4) | cat)]);
            pack_amplitude(ac, cat);
            run_len = '0;
          end
        end
        if (position == 63) begin
          position = '0;
          run_len  = '0;
        end else begin
          position = position + 1;
        end
      end
      default: ;  // unused opcode: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building blocks.
  // ---------------------------------------------------------------------------
  function automatic void queue_item(opcode_e op, logic [1:0] comp, logic [10:0] coef);
    item_t it;
    it.opcode      = op;
    it.component   = comp;
    it.coefficient = coef;
    pending_items.push_back(it);
  endfunction

  // Random coefficient skewed toward zeros and small values, with some extremes.
  function automatic logic [10:0] pick_coef(int zero_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return '0;
    r = $urandom_range(99);
    if (r < 60) return 11'($signed($urandom_range(30)) - 15);
    if (r < 85) return 11'($urandom);
    case ($urandom_range(3))
      0: return 11'h400;   // most negative
      1: return 11'h3FF;   // most positive
      2: return 11'h401;
      default: return 11'h7FF;
    endcase
  endfunction

  // One full block; a few blocks swap component mid-block.
  function automatic void queue_block(logic [1:0] comp);
    logic [1:0] c;
    int zero_pct;
    zero_pct = $urandom_range(40, 95);
    c = comp;
    for (int p = 0; p < 64; p++) begin
      if ($urandom_range(49) == 0) c = 2'($urandom_range(3));
      queue_item(OP_COEF, c, pick_coef(zero_pct));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers pending transactions, with random idle bursts.
  // ---------------------------------------------------------------------------
  int src_idle;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_if.valid   <= 1'b0;
      coef_if.payload <= '0;
      src_idle        = 0;
    end else begin
      if (coef_if.valid && coef_if.ready) begin
        encode_item(item_t'(coef_if.payload));
        n_items_sent++;
      end
      if (!coef_if.valid || coef_if.ready) begin
        if (src_idle > 0) begin
          src_idle--;
          coef_if.valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     (quiet_tail || $urandom_range(9) != 0)) begin
          coef_if.valid   <= 1'b1;
          coef_if.payload <= pending_items.pop_front();
        end else begin
          coef_if.valid <= 1'b0;
          if (pending_items.size() > 0) src_idle = $urandom_range(1, 9);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each byte against the oldest expectation; drives ready.
  // ---------------------------------------------------------------------------
  int sink_idle;
  int hold_cycles;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.ready <= 1'b0;
      sink_idle   = 0;
      hold_cycles = 0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        result_t got;
        result_t want;
        got = result_t'(byte_if.payload);
        n_bytes_seen++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte %02h (image_end %0b)", got.out_byte, got.image_end);
          n_errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
            n_errors++;
          end
          if (got.image_end !== want.image_end) begin
            $error("image_end: expected %0b, actual %0b", want.image_end, got.image_end);
            n_errors++;
          end
        end
      end
      // Hold off for a long stretch once, so the encoder backs up to its input.
      if (hold_long) begin
        hold_long   = 1'b0;
        hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        byte_if.ready <= 1'b0;
      end else if (sink_idle > 0) begin
        sink_idle--;
        byte_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(7) == 0) begin
        sink_idle = $urandom_range(1, 9);
        byte_if.ready <= 1'b0;
      end else begin
        byte_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed items, random images, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    coef_if.valid   = 1'b0;
    coef_if.payload = '0;
    byte_if.ready   = 1'b0;
    n_errors = 0;
    n_bytes_seen = 0;
    n_items_sent = 0;
    quiet_tail = 1'b0;
    hold_long = 1'b0;
    pred_dc[0] = '0; pred_dc[1] = '0; pred_dc[2] = '0;
    acc_bits = '0; acc_count = '0; run_len = '0; position = '0;
    build_tables();

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: DC extremes per component, out-of-range component, AC clamp,
    // unused opcode, start discarding partial bits, finish with padding.
    queue_item(OP_START, 2'd0, '0);
    queue_item(OP_COEF, 2'd0, 11'h3FF);     // DC +1023
    queue_item(OP_COEF, 2'd0, 11'h400);     // AC -1024 clamps to -1023
    queue_item(OP_COEF, 2'd1, 11'h3FF);     // AC +1023, chroma table
    queue_item(OP_COEF, 2'd3, 11'h001);     // component 3 acts as Cr
    queue_item(OP_NONE, 2'd2, 11'h7FF);     // ignored
    queue_item(OP_START, 2'd1, '0);         // drops buffered bits
    queue_item(OP_COEF, 2'd2, 11'h400);     // DC -1024
    queue_item(OP_FINISH, 2'd0, '0);        // pad and end of image
    // Block with a 40-zero run (ZRL twice), then zeros to the end (EOB).
    queue_item(OP_COEF, 2'd1, 11'h3FF);     // Cb DC diff 1023 against a cleared predictor
    for (int p = 1; p < 64; p++)
      queue_item(OP_COEF, 2'd1, (p == 41) ? 11'h7FF : 11'h000);
    queue_item(OP_COEF, 2'd3, 11'h400);     // Cr DC against its -1024 predictor: zero diff
    queue_item(OP_FINISH, 2'd2, '0);

    // Random images: start in most, one or two blocks, finish; some noise items between.
    for (int img = 0; img < 4; img++) begin
      if ($urandom_range(3) != 0) queue_item(OP_START, 2'($urandom), 11'($urandom));
      for (int b = 0; b < 1 + int'(img == 1); b++) queue_block(2'($urandom_range(2)));
      if ($urandom_range(1)) queue_item(OP_NONE, 2'($urandom), 11'($urandom));
      for (int p = 0; p < $urandom_range(1, 20); p++)  // abandoned partial block
        queue_item(OP_COEF, 2'($urandom), pick_coef(50));
      queue_item(OP_FINISH, 2'($urandom), 11'($urandom));
    end

    // Let the sender run ahead while the receiver holds off.
    wait (pending_items.size() < 250);
    hold_long = 1'b1;
    wait (pending_items.size() < 80);
    quiet_tail = 1'b1;

    wait (pending_items.size() == 0 && !coef_if.valid && expected_bytes.size() == 0);
    repeat (40) @(posedge clk_i);

    $display("covered %0d input items and %0d output bytes, incl. clamp, ZRL, EOB, stuffing",
             n_items_sent, n_bytes_seen);
    if (expected_bytes.size() != 0) begin
      $error("%0d expected bytes never arrived", expected_bytes.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("tb_jpeg_huffman_block_encoder: done, clean");
    end else begin
      $display("tb_jpeg_huffman_block_encoder: done, errors");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2000000;
    $display("tb_jpeg_huffman_block_encoder: done, errors");
    $finish;
  end

endmodule
